### design/bcpn_pkg.sv
package bcpn_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned KeyW     = CoordW + 2;
  localparam int unsigned FaceW    = 3;
  localparam int unsigned NumAxes  = 3;
  localparam int unsigned NumFaces = 2 * NumAxes;
  localparam int unsigned RegIdxW  = 3;

  // 1.0 in Q16.16
  localparam logic signed [CoordW-1:0] OneQ16 = 32'sh0001_0000;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [KeyW-1:0]   key_t;

  typedef enum logic [FaceW-1:0] {
    FacePosX = 3'd0,
    FacePosY = 3'd1,
    FacePosZ = 3'd2,
    FaceNegX = 3'd3,
    FaceNegY = 3'd4,
    FaceNegZ = 3'd5
  } face_e;

  typedef enum logic [RegIdxW-1:0] {
    RegLowX  = 3'd0,
    RegLowY  = 3'd1,
    RegLowZ  = 3'd2,
    RegHighX = 3'd3,
    RegHighY = 3'd4,
    RegHighZ = 3'd5
  } reg_e;

  // One face candidate: smaller key wins, the lower face code wins a tie
  typedef struct packed {
    logic  en;
    key_t  key;
    face_e face;
  } cand_t;

  // Per-axis result of the first stage
  typedef struct packed {
    coord_t clamp;
    key_t   key_pos;
    key_t   key_neg;
  } axis_t;

endpackage

### design/bcpn_axis.sv
module bcpn_axis (
  input  bcpn_pkg::coord_t p_i,
  input  bcpn_pkg::coord_t lo_i,
  input  bcpn_pkg::coord_t hi_i,
  input  logic             inside_i,
  output logic             in_range_o,
  output bcpn_pkg::axis_t  axis_o
);

  logic          below;
  logic          above_hi;
  logic          above;
  bcpn_pkg::key_t pe;
  bcpn_pkg::key_t le;
  bcpn_pkg::key_t he;

  assign below    = p_i < lo_i;
  assign above_hi = p_i > hi_i;
  assign above    = !below && above_hi;

  assign in_range_o = !below && !above_hi;

  assign pe = {{2{p_i[bcpn_pkg::CoordW-1]}}, p_i};
  assign le = {{2{lo_i[bcpn_pkg::CoordW-1]}}, lo_i};
  assign he = {{2{hi_i[bcpn_pkg::CoordW-1]}}, hi_i};

  always_comb begin
    axis_o.clamp = below ? lo_i : (above ? hi_i : p_i);
    // Inside: plane distances. Outside: +face keys q-p, -face keys p-q, so the
    // largest signed offset component becomes the smallest key.
    if (inside_i || above) begin
      axis_o.key_pos = he - pe;
    end else if (below) begin
      axis_o.key_pos = le - pe;
    end else begin
      axis_o.key_pos = '0;
    end
    if (inside_i || below) begin
      axis_o.key_neg = pe - le;
    end else if (above) begin
      axis_o.key_neg = pe - he;
    end else begin
      axis_o.key_neg = '0;
    end
  end

endmodule

### design/bcpn_pick.sv
module bcpn_pick (
  input  bcpn_pkg::cand_t a_i,
  input  bcpn_pkg::cand_t b_i,
  output bcpn_pkg::cand_t y_o
);

  // a comes earlier in face order: b must be strictly smaller to win
  assign y_o = (b_i.en && (!a_i.en || (b_i.key < a_i.key))) ? b_i : a_i;

endmodule

### design/box_closest_point_and_normal.sv
// Closest point on an axis-aligned box surface and its face, for a stream of
// signed Q16.16 query points. One beat in, one beat out; a new point is taken
// every cycle while the output is not stalled, and each result passes the four
// register stages: per-axis clamp and face keys, pairwise face minimum, final
// face minimum, output register. Back-pressure stalls only as far as needed:
// empty stages still fill while the output waits. The box corners come from
// the write port and must only change while no point is in flight. DIMS = 2
// drops the z axis: near_z reads 0 and the z faces are never chosen.
module box_closest_point_and_normal #(
  parameter int unsigned DIMS = 3
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // point_x, point_y, point_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata   // near_x, near_y, near_z, face_index, was_inside, pad
);

  localparam int unsigned NA = bcpn_pkg::NumAxes;
  localparam int unsigned NF = bcpn_pkg::NumFaces;
  localparam int unsigned CW = bcpn_pkg::CoordW;

  bcpn_pkg::coord_t low_q  [NA];
  bcpn_pkg::coord_t high_q [NA];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NA; a++) begin
        low_q[a]  <= '0;
        high_q[a] <= bcpn_pkg::OneQ16;
      end
    end else if (cfg_we_i) begin
      case (bcpn_pkg::reg_e'(cfg_idx_i))
        bcpn_pkg::RegLowX:  low_q[0]  <= cfg_data_i;
        bcpn_pkg::RegLowY:  low_q[1]  <= cfg_data_i;
        bcpn_pkg::RegLowZ:  low_q[2]  <= cfg_data_i;
        bcpn_pkg::RegHighX: high_q[0] <= cfg_data_i;
        bcpn_pkg::RegHighY: high_q[1] <= cfg_data_i;
        bcpn_pkg::RegHighZ: high_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage handshake
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 1: clamp and face keys
  bcpn_pkg::coord_t p_in  [NA];
  bcpn_pkg::coord_t lo_in [NA];
  bcpn_pkg::coord_t hi_in [NA];
  bcpn_pkg::axis_t  ax    [NA];
  logic [NA-1:0]    in_range;
  logic             in_box;
  bcpn_pkg::cand_t  cand  [NF];

  assign in_box = &in_range;

  for (genvar a = 0; a < NA; a++) begin : g_axis
    localparam bit Used = (a < DIMS);
    // an unused axis sees zeros everywhere, so it is in range and clamps to 0
    assign p_in[a]  = Used ? s_axis_tdata[a*CW +: CW] : '0;
    assign lo_in[a] = Used ? low_q[a]  : '0;
    assign hi_in[a] = Used ? high_q[a] : '0;

    bcpn_axis u_axis (
      .p_i        (p_in[a]),
      .lo_i       (lo_in[a]),
      .hi_i       (hi_in[a]),
      .inside_i   (in_box),
      .in_range_o (in_range[a]),
      .axis_o     (ax[a])
    );

    assign cand[a].en        = Used;
    assign cand[a].key       = ax[a].key_pos;
    assign cand[a].face      = bcpn_pkg::face_e'(3'(a));
    assign cand[a + NA].en   = Used;
    assign cand[a + NA].key  = ax[a].key_neg;
    assign cand[a + NA].face = bcpn_pkg::face_e'(3'(a + NA));
  end

  bcpn_pkg::cand_t  cand1_q   [NF];
  bcpn_pkg::coord_t clamp1_q  [NA];
  bcpn_pkg::coord_t lo1_q     [NA];
  bcpn_pkg::coord_t hi1_q     [NA];
  logic             inside1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      for (int f = 0; f < NF; f++) cand1_q[f] <= cand[f];
      for (int a = 0; a < NA; a++) begin
        clamp1_q[a] <= ax[a].clamp;
        lo1_q[a]    <= lo_in[a];
        hi1_q[a]    <= hi_in[a];
      end
      inside1_q <= in_box;
    end
  end

  // stage 2: pairwise minimum in face order
  bcpn_pkg::cand_t  pair    [NA];
  bcpn_pkg::cand_t  pair2_q [NA];
  bcpn_pkg::coord_t clamp2_q [NA];
  bcpn_pkg::coord_t lo2_q    [NA];
  bcpn_pkg::coord_t hi2_q    [NA];
  logic             inside2_q;

  for (genvar k = 0; k < NA; k++) begin : g_pair
    bcpn_pick u_pick (
      .a_i (cand1_q[2*k]),
      .b_i (cand1_q[2*k + 1]),
      .y_o (pair[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      for (int k = 0; k < NA; k++) pair2_q[k] <= pair[k];
      for (int a = 0; a < NA; a++) begin
        clamp2_q[a] <= clamp1_q[a];
        lo2_q[a]    <= lo1_q[a];
        hi2_q[a]    <= hi1_q[a];
      end
      inside2_q <= inside1_q;
    end
  end

  // stage 3: final minimum
  bcpn_pkg::cand_t  win01;
  bcpn_pkg::cand_t  win;
  bcpn_pkg::face_e  face3_q;
  bcpn_pkg::coord_t clamp3_q [NA];
  bcpn_pkg::coord_t lo3_q    [NA];
  bcpn_pkg::coord_t hi3_q    [NA];
  logic             inside3_q;

  bcpn_pick u_pick_a (
    .a_i (pair2_q[0]),
    .b_i (pair2_q[1]),
    .y_o (win01)
  );

  bcpn_pick u_pick_b (
    .a_i (win01),
    .b_i (pair2_q[2]),
    .y_o (win)
  );

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      face3_q <= win.face;
      for (int a = 0; a < NA; a++) begin
        clamp3_q[a] <= clamp2_q[a];
        lo3_q[a]    <= lo2_q[a];
        hi3_q[a]    <= hi2_q[a];
      end
      inside3_q <= inside2_q;
    end
  end

  // stage 4: move the chosen coordinate onto its face, register the beat
  bcpn_pkg::coord_t near   [NA];
  bcpn_pkg::coord_t near4_q [NA];
  bcpn_pkg::face_e  face4_q;
  logic             inside4_q;

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      if (inside3_q && (face3_q == bcpn_pkg::face_e'(3'(a)))) begin
        near[a] = hi3_q[a];
      end else if (inside3_q && (face3_q == bcpn_pkg::face_e'(3'(a + NA)))) begin
        near[a] = lo3_q[a];
      end else begin
        near[a] = clamp3_q[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      for (int a = 0; a < NA; a++) near4_q[a] <= near[a];
      face4_q   <= face3_q;
      inside4_q <= inside3_q;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {4'b0000, inside4_q, face4_q, near4_q[2], near4_q[1], near4_q[0]};

endmodule

### design/bcpn_chk.sv
module bcpn_chk #(
  parameter int unsigned DIMS = 3
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         cfg_we_i,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);

  logic       in_acc;
  logic       out_acc;
  logic [3:0] flight_q;
  logic [3:0] flight_d;
  logic [2:0] face;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign face    = m_axis_tdata[98:96];

  always_comb begin
    flight_d = flight_q;
    if (in_acc && !out_acc) flight_d = flight_q + 4'd1;
    if (!in_acc && out_acc) flight_d = flight_q - 4'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q <= '0;
    end else begin
      flight_q <= flight_d;
    end
  end

  // hold a stalled result
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // no result without a point behind it
  a_no_invent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> flight_q != 4'd0)
    else $error("result without accepted point");

  // four stages hold at most four points
  a_depth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    flight_q <= 4'd4)
    else $error("more points in flight than stages");

  a_face_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> face <= bcpn_pkg::FaceNegZ &&
      (DIMS > 2 || (face != bcpn_pkg::FacePosZ && face != bcpn_pkg::FaceNegZ)))
    else $error("illegal face index");

  // box corners change only with the pipeline empty
  a_cfg_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> flight_q == 4'd0)
    else $error("box written with points in flight");

endmodule

bind box_closest_point_and_normal bcpn_chk #(.DIMS(DIMS)) u_bcpn_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/tb.sv
module tb;
  import bcpn_pkg::*;

  localparam int unsigned Dims         = NumAxes;
  localparam int unsigned NumPhases    = 16;
  localparam int unsigned PhaseItems   = 52;
  localparam int unsigned LatencyWait  = 8;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned CycleLimit   = 200_000;
  localparam int unsigned StressPhase  = 7;

  // indexes past the last box register; writes there must change nothing
  localparam logic [RegIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [RegIdxW-1:0] RegSpare7 = 3'd7;

  localparam coord_t MinC  = 32'sh8000_0000;
  localparam coord_t MaxC  = 32'sh7FFF_FFFF;
  localparam coord_t Half  = OneQ16 >>> 1;
  localparam coord_t Tenth = OneQ16 / 10;
  localparam coord_t Nine  = OneQ16 - Tenth;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } point_t;

  typedef struct packed {
    logic [3:0] pad;
    logic       was_in;
    face_e      face;
    coord_t     z;
    coord_t     y;
    coord_t     x;
  } surf_t;

  typedef struct {
    coord_t px, py, pz;
    bit     known;
    coord_t nx, ny, nz;
    face_e  face;
    bit     was_in;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [31:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;   // point_x, point_y, point_z
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;        // near_x, near_y, near_z, face_index, was_inside, pad

  longint      box_lo [3];
  longint      box_hi [3];
  surf_t       near_q [$];
  dir_row_t    dir_rows [$];
  bit          burst;
  bit          hold_long;
  int unsigned err_count;
  int unsigned points_sent;
  int unsigned results_seen;
  int unsigned inside_seen;
  logic [5:0]  faces_seen = '0;
  int unsigned cycles;

  box_closest_point_and_normal #(
    .DIMS(Dims)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycles, near_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic face_e face_of(int ax, bit neg);
    case (ax)
      0:       return neg ? FaceNegX : FacePosX;
      1:       return neg ? FaceNegY : FacePosY;
      default: return neg ? FaceNegZ : FacePosZ;
    endcase
  endfunction

  function automatic coord_t sat(longint v);
    if (v < MinC) return MinC;
    if (v > MaxC) return MaxC;
    return coord_t'(v);
  endfunction

  // Closest surface point and face for the box currently held in box_lo/box_hi
  function automatic surf_t closest_on_box(point_t pt);
    longint p [3];
    longint q [3];
    longint d [3];
    longint best, cand;
    int     ax, f, best_ax;
    bit     best_neg, in_box;
    surf_t  r;
    p[0] = pt.x;
    p[1] = pt.y;
    p[2] = pt.z;
    for (ax = Dims; ax < 3; ax++) p[ax] = 0;
    in_box = 1'b1;
    for (ax = 0; ax < 3; ax++) begin
      q[ax] = p[ax];
      d[ax] = 0;
      if (ax < Dims && (p[ax] < box_lo[ax] || p[ax] > box_hi[ax])) in_box = 1'b0;
    end
    best_ax  = 0;
    best_neg = 1'b0;
    if (in_box) begin
      best = box_hi[0] - p[0];
    end else begin
      for (ax = 0; ax < Dims; ax++) begin
        if (p[ax] < box_lo[ax]) q[ax] = box_lo[ax];
        else if (p[ax] > box_hi[ax]) q[ax] = box_hi[ax];
        d[ax] = p[ax] - q[ax];
      end
      best = d[0];
    end
    // inside: nearest plane wins; outside: largest outward offset wins; first one on a tie
    for (f = 1; f < 2 * Dims; f++) begin
      ax = f % Dims;
      if (in_box) cand = (f < Dims) ? box_hi[ax] - p[ax] : p[ax] - box_lo[ax];
      else        cand = (f < Dims) ? d[ax] : -d[ax];
      if (in_box ? (cand < best) : (cand > best)) begin
        best     = cand;
        best_ax  = ax;
        best_neg = (f >= Dims);
      end
    end
    if (in_box) q[best_ax] = best_neg ? box_lo[best_ax] : box_hi[best_ax];
    r.pad    = '0;
    r.was_in = in_box;
    r.face   = face_of(best_ax, best_neg);
    r.x      = coord_t'(q[0]);
    r.y      = coord_t'(q[1]);
    r.z      = coord_t'(q[2]);
    return r;
  endfunction

  function automatic coord_t rand_coord(int ax, int unsigned mode);
    longint v, span;
    case (mode)
      0, 1: v = coord_t'($urandom);
      2, 3, 4, 5: begin
        if (box_lo[ax] <= box_hi[ax]) begin
          span = box_hi[ax] - box_lo[ax] + 1;
          v = box_lo[ax] + (longint'({32'd0, $urandom}) % span);
        end else begin
          v = $urandom_range(0, 1) ? box_lo[ax] : box_hi[ax];
        end
      end
      6: v = box_lo[ax] + int'($urandom_range(0, 4)) - 2;
      7: v = box_hi[ax] + int'($urandom_range(0, 4)) - 2;
      8: v = ((box_lo[ax] + box_hi[ax]) >>> 1) + int'($urandom_range(0, 2)) - 1;
      default: v = $urandom_range(0, 1) ? longint'(MinC) + $urandom_range(0, 3)
                                        : longint'(MaxC) - $urandom_range(0, 3);
    endcase
    return sat(v);
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    err_count++;
    $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
  endtask

  // Offer one point, hold it until taken, then queue what must come back
  task automatic send_point(point_t pt, bit known, surf_t want);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pt;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    near_q.push_back(known ? want : closest_on_box(pt));
    points_sent++;
  endtask

  task automatic settle();
    while (near_q.size() != 0) @(posedge clk_i);
    repeat (LatencyWait) @(posedge clk_i);
  endtask

  task automatic load_box();
    reg_e lo_regs [3];
    reg_e hi_regs [3];
    int   k;
    lo_regs = '{RegLowX, RegLowY, RegLowZ};
    hi_regs = '{RegHighX, RegHighY, RegHighZ};
    for (k = 0; k < 8; k++) begin
      cfg_we_i <= 1'b1;
      if (k < 3) begin
        cfg_idx_i  <= lo_regs[k];
        cfg_data_i <= coord_t'(box_lo[k]);
      end else if (k < 6) begin
        cfg_idx_i  <= hi_regs[k-3];
        cfg_data_i <= coord_t'(box_hi[k-3]);
      end else begin
        cfg_idx_i  <= (k == 6) ? RegSpare6 : RegSpare7;
        cfg_data_i <= $urandom;
      end
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin : drain_side
    int unsigned gap;
    bit          held;
    held = 1'b0;
    wait (rst_ni);
    forever begin
      gap = burst ? 0 : $urandom_range(0, 12);
      if (hold_long && !held) begin
        gap  = LongHold;
        held = 1'b1;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin : result_check
    surf_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = surf_t'(m_axis_tdata);
      if (near_q.size() == 0) begin
        err_count++;
        $display("%0t: result beat with nothing expected: %h", $time, m_axis_tdata);
      end else begin
        want = near_q.pop_front();
        results_seen++;
        if (got.was_in) inside_seen++;
        if (got.face <= FaceNegZ) faces_seen[got.face] = 1'b1;
        if (got.x !== want.x) note_mismatch("near_x", want.x, got.x);
        if (got.y !== want.y) note_mismatch("near_y", want.y, got.y);
        if (got.z !== want.z) note_mismatch("near_z", want.z, got.z);
        if (got.face !== want.face) note_mismatch("face_index", want.face, got.face);
        if (got.was_in !== want.was_in) note_mismatch("was_inside", want.was_in, got.was_in);
      end
    end
  end

  initial begin : stimulus
    int          ph, n, ax;
    int unsigned style, mode;
    coord_t      c [3];
    point_t      pt;
    surf_t       want;
    dir_row_t    row;

    for (ax = 0; ax < 3; ax++) begin
      box_lo[ax] = 0;
      box_hi[ax] = OneQ16;
    end

    // Reset box is the unit cube; typed rows read straight off the face rules
    dir_rows.push_back('{0, 0, 0, 1'b1, 0, 0, 0, FaceNegX, 1'b1});
    dir_rows.push_back('{OneQ16, OneQ16, OneQ16, 1'b1, OneQ16, OneQ16, OneQ16, FacePosX, 1'b1});
    dir_rows.push_back('{Half, Half, Half, 1'b1, OneQ16, Half, Half, FacePosX, 1'b1});
    dir_rows.push_back('{MaxC, MaxC, MaxC, 1'b1, OneQ16, OneQ16, OneQ16, FacePosX, 1'b0});
    dir_rows.push_back('{MinC, MinC, MinC, 1'b1, 0, 0, 0, FaceNegX, 1'b0});
    dir_rows.push_back('{MinC, MaxC, Half, 1'b1, 0, OneQ16, Half, FaceNegX, 1'b0});
    dir_rows.push_back('{Nine, Half, Half, 1'b0, 0, 0, 0, FacePosX, 1'b0});
    dir_rows.push_back('{Half, Nine, Half, 1'b0, 0, 0, 0, FacePosX, 1'b0});
    dir_rows.push_back('{Half, Half, Nine, 1'b0, 0, 0, 0, FacePosX, 1'b0});
    dir_rows.push_back('{Tenth, Half, Half, 1'b0, 0, 0, 0, FacePosX, 1'b0});
    dir_rows.push_back('{Half, Tenth, Half, 1'b0, 0, 0, 0, FacePosX, 1'b0});
    dir_rows.push_back('{Half, Half, Tenth, 1'b0, 0, 0, 0, FacePosX, 1'b0});
    dir_rows.push_back('{OneQ16 + 1, Half, Half, 1'b0, 0, 0, 0, FacePosX, 1'b0});
    dir_rows.push_back('{Half, OneQ16 + 1, Half, 1'b0, 0, 0, 0, FacePosX, 1'b0});
    dir_rows.push_back('{Half, Half, OneQ16 + 1, 1'b0, 0, 0, 0, FacePosX, 1'b0});
    dir_rows.push_back('{-1, Half, Half, 1'b0, 0, 0, 0, FacePosX, 1'b0});
    dir_rows.push_back('{Half, -1, Half, 1'b0, 0, 0, 0, FacePosX, 1'b0});
    dir_rows.push_back('{Half, Half, -1, 1'b0, 0, 0, 0, FacePosX, 1'b0});
    dir_rows.push_back('{0, Half, Half, 1'b0, 0, 0, 0, FacePosX, 1'b0});
    dir_rows.push_back('{Half, Half, 0, 1'b0, 0, 0, 0, FacePosX, 1'b0});
    dir_rows.push_back('{2 * OneQ16, -OneQ16, 3 * OneQ16, 1'b0, 0, 0, 0, FacePosX, 1'b0});
    dir_rows.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0,
                         0, 0, 0, FacePosX, 1'b0});
    dir_rows.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0,
                         0, 0, 0, FacePosX, 1'b0});
    dir_rows.push_back('{MaxC, 0, MinC, 1'b0, 0, 0, 0, FacePosX, 1'b0});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      pt  = {row.pz, row.py, row.px};
      want.pad    = '0;
      want.was_in = row.was_in;
      want.face   = row.face;
      want.x      = row.nx;
      want.y      = row.ny;
      want.z      = row.nz;
      send_point(pt, row.known, want);
    end
    s_axis_tvalid <= 1'b0;
    settle();

    for (ph = 0; ph < NumPhases; ph++) begin
      for (ax = 0; ax < 3; ax++) begin
        case (ph)
          0: ;  // stay on the reset box
          1: begin
            box_lo[ax] = -longint'($urandom_range(0, 4 * OneQ16));
            box_hi[ax] = box_lo[ax] + $urandom_range(1, 8 * OneQ16);
          end
          2: begin
            box_lo[ax] = MinC;
            box_hi[ax] = MaxC;
          end
          3: begin
            box_lo[ax] = coord_t'($urandom);
            box_hi[ax] = box_lo[ax];
          end
          4: begin
            box_lo[ax] = (ax == 2) ? Half : -OneQ16;
            box_hi[ax] = (ax == 2) ? Half : OneQ16;
          end
          5: begin
            box_lo[ax] = (ax == 0) ? OneQ16 : -OneQ16;
            box_hi[ax] = (ax == 0) ? -OneQ16 : OneQ16;
          end
          6: begin
            box_lo[ax] = OneQ16 + $urandom_range(0, OneQ16);
            box_hi[ax] = -longint'($urandom_range(0, OneQ16));
          end
          7: begin
            box_lo[ax] = -2 * OneQ16;
            box_hi[ax] = 2 * OneQ16;
          end
          8: begin
            box_lo[ax] = MinC;
            box_hi[ax] = longint'(MinC) + OneQ16;
          end
          9: begin
            box_lo[ax] = longint'(MaxC) - OneQ16;
            box_hi[ax] = MaxC;
          end
          10: begin
            // unordered corners: often inverted on some axis
            box_lo[ax] = coord_t'($urandom);
            box_hi[ax] = coord_t'($urandom);
          end
          default: begin
            box_lo[ax] = coord_t'($urandom);
            box_hi[ax] = sat(box_lo[ax] + longint'($urandom >> $urandom_range(0, 31)));
          end
        endcase
      end
      if (ph != 0) load_box();

      burst = (ph % 4 == 3) || (ph == StressPhase);
      // stall the output for a long stretch while points keep coming
      if (ph == StressPhase) hold_long = 1'b1;

      for (n = 0; n < PhaseItems; n++) begin
        style = $urandom_range(0, 9);
        for (ax = 0; ax < 3; ax++) begin
          if (style == 0)     mode = 8;
          else if (style < 7) mode = $urandom_range(2, 8);
          else                mode = $urandom_range(0, 9);
          c[ax] = rand_coord(ax, mode);
        end
        pt = {c[2], c[1], c[0]};
        send_point(pt, 1'b0, '0);
      end
      s_axis_tvalid <= 1'b0;
      settle();
    end
    burst = 1'b0;

    $display("Sent %0d query points over %0d box settings; %0d results checked.",
             points_sent, NumPhases, results_seen);
    $display("Inside or on the box: %0d; faces seen (-z..+x): %b; mismatches: %0d.",
             inside_seen, faces_seen, err_count);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
